// ===== rtl/core/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

   localparam int DATA_W      = 32;
   localparam int PROD_W      = 64;
   localparam int COUNT_W     = 9;
   localparam int INDEX_W     = 8;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DIV_STEPS   = 32;
   localparam int DIV_CNT_W   = 6;

   localparam logic [0:0] CMD_LOAD  = 1'b0;
   localparam logic [0:0] CMD_QUERY = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] ADDR_POINT_COUNT = 3'd0;

   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic write_point;
      logic scan_step;
      logic diff;
      logic mul;
      logic div_start;
      logic result_found;
      logic result_miss;
      logic out_load;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic few_points;
      logic seg_valid;
      logic seg_match;
      logic seg_last;
      logic div_done;
      logic out_busy;
   } dp_status_type;

endpackage

// ===== rtl/core/piecewise_linear_interpolator_unit.sv =====
// A load transaction writes its table entry when it is accepted; a query scans the table one entry
// per cycle and then runs a bit-serial divider.
// One transaction is handled at a time; the next is accepted while a finished result waits.
// Reset clears the controller, the output register and point_count; table contents
// are undefined until written.
module piecewise_linear_interpolator_unit #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: point_index[7:0], point_x[39:8], point_y[71:40], query_x[103:72]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [103:0]                       req_tdata,
   // req_tuser: cmd[0]
   input  logic [0:0]                         req_tuser,
   // rsp_tdata: value[31:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [31:0]                        rsp_tdata,
   // rsp_tuser: found[0], saturated[1]
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [pli_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pli_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pli_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [pli_pkg::COUNT_W-1:0] point_count_ff;
   logic                        csr_write;
   pli_pkg::ctrl_cmd_type       cmd;
   pli_pkg::dp_status_type      status;
   logic [pli_pkg::DATA_W-1:0]  rsp_value;
   logic                        rsp_found;
   logic                        rsp_saturated;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else if (csr_write && (csr_paddr == pli_pkg::ADDR_POINT_COUNT)) begin
         point_count_ff <= csr_pwdata[pli_pkg::COUNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == pli_pkg::ADDR_POINT_COUNT) ?
                       pli_pkg::CSR_DATA_W'(point_count_ff) : '0;

   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser[0]),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pli_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .point_index   (req_tdata[7:0]),
      .point_x       (req_tdata[39:8]),
      .point_y       (req_tdata[71:40]),
      .query_x       (req_tdata[103:72]),
      .point_count   (point_count_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_value     (rsp_value),
      .rsp_found     (rsp_found),
      .rsp_saturated (rsp_saturated)
   );

   assign rsp_tdata = rsp_value;
   assign rsp_tuser = {rsp_saturated, rsp_found};

endmodule

// ===== rtl/core/pli_divider.sv =====
// Restoring divider, one quotient bit per cycle, for a 64-bit dividend whose quotient fits 32 bits.
module pli_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pli_pkg::PROD_W-1:0]    dividend,
   input  logic [pli_pkg::DATA_W-1:0]    divisor,
   output logic                          done,
   output logic [pli_pkg::DATA_W-1:0]    quotient
);

   logic [pli_pkg::DATA_W-1:0]    rem_ff;
   logic [pli_pkg::DATA_W-1:0]    rem_in;
   logic [pli_pkg::DATA_W-1:0]    quo_ff;
   logic [pli_pkg::DIV_CNT_W-1:0] step_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [pli_pkg::DATA_W:0]      trial;
   logic [pli_pkg::DATA_W:0]      trial_diff;
   logic                          trial_ge;

   // The upper half of the dividend is below the divisor, so the partial
   // remainder always fits the divisor width and the trial one bit more.
   always_comb begin
      trial      = {rem_ff, quo_ff[pli_pkg::DATA_W-1]};
      trial_diff = trial - {1'b0, divisor};
      trial_ge   = (trial >= {1'b0, divisor});
      rem_in     = trial_ge ? trial_diff[pli_pkg::DATA_W-1:0] : trial[pli_pkg::DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == pli_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[pli_pkg::PROD_W-1:pli_pkg::DATA_W];
         quo_ff <= dividend[pli_pkg::DATA_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[pli_pkg::DATA_W-2:0], trial_ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/pli_datapath.sv =====
// Breakpoint tables, segment scan, multiply, divide and the result register.
module pli_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pli_pkg::ctrl_cmd_type           cmd,
   output pli_pkg::dp_status_type          status,
   input  logic [pli_pkg::INDEX_W-1:0]     point_index,
   input  logic [pli_pkg::DATA_W-1:0]      point_x,
   input  logic [pli_pkg::DATA_W-1:0]      point_y,
   input  logic [pli_pkg::DATA_W-1:0]      query_x,
   input  logic [pli_pkg::COUNT_W-1:0]     point_count,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [pli_pkg::DATA_W-1:0]      rsp_value,
   output logic                            rsp_found,
   output logic                            rsp_saturated
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int N_W   = (IDX_W + 1 > pli_pkg::COUNT_W) ? IDX_W + 1 : pli_pkg::COUNT_W;

   logic [pli_pkg::DATA_W-1:0] x_mem [TABLE_DEPTH];
   logic [pli_pkg::DATA_W-1:0] y_mem [TABLE_DEPTH];

   logic [pli_pkg::DATA_W-1:0] query_ff;
   logic [N_W-1:0]             n_ff;
   logic [N_W-1:0]             n_in;
   logic [N_W-1:0]             addr_ff;
   logic [pli_pkg::DATA_W-1:0] cur_x_ff;
   logic [pli_pkg::DATA_W-1:0] cur_y_ff;
   logic [pli_pkg::DATA_W-1:0] prev_x_ff;
   logic [pli_pkg::DATA_W-1:0] prev_y_ff;
   logic                       index_ok;

   logic [pli_pkg::DATA_W:0]   dy;
   logic [pli_pkg::DATA_W:0]   dy_mag;
   logic [pli_pkg::DATA_W:0]   dq;
   logic [pli_pkg::DATA_W:0]   dx;
   logic                       neg_ff;
   logic [pli_pkg::DATA_W-1:0] mag_ff;
   logic [pli_pkg::DATA_W-1:0] dq_ff;
   logic [pli_pkg::DATA_W-1:0] dx_ff;
   logic [pli_pkg::DATA_W-1:0] y0_ff;
   logic [pli_pkg::PROD_W-1:0] prod_ff;

   logic                       div_done;
   logic [pli_pkg::DATA_W-1:0] quotient;
   logic [pli_pkg::DATA_W+1:0] sum;
   logic                       sum_over;
   logic                       sum_under;

   logic [pli_pkg::DATA_W-1:0] res_value_ff;
   logic                       res_found_ff;
   logic                       res_sat_ff;
   logic                       rsp_valid_ff;
   logic [pli_pkg::DATA_W-1:0] rsp_value_ff;
   logic                       rsp_found_ff;
   logic                       rsp_sat_ff;

   assign index_ok = (32'(point_index) < 32'(TABLE_DEPTH));
   assign n_in     = (N_W'(point_count) > N_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH)
                                                              : N_W'(point_count);

   // Table writes and the sequential scan read, one entry per cycle.
   always_ff @(posedge clock) begin
      if (cmd.write_point && index_ok) begin
         x_mem[IDX_W'(point_index)] <= point_x;
         y_mem[IDX_W'(point_index)] <= point_y;
      end
      if (cmd.scan_step) begin
         cur_x_ff  <= x_mem[addr_ff[IDX_W-1:0]];
         cur_y_ff  <= y_mem[addr_ff[IDX_W-1:0]];
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (cmd.capture) begin
         addr_ff <= '0;
      end else if (cmd.scan_step) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         query_ff <= query_x;
         n_ff     <= n_in;
      end
   end

   // The segment under test lies between prev (x[i]) and cur (x[i+1]),
   // valid once two entries have been read.
   always_comb begin
      status.few_points = (n_ff < N_W'(2));
      status.seg_valid  = (addr_ff >= N_W'(2));
      status.seg_match  = ($signed(prev_x_ff) <= $signed(query_ff)) &&
                          ($signed(query_ff) < $signed(cur_x_ff));
      status.seg_last   = (addr_ff == n_ff);
      status.div_done   = div_done;
      status.out_busy   = rsp_valid_ff && !rsp_tready;
   end

   // Differences span at most 2^32-1, so magnitudes fit 32 bits unsigned.
   always_comb begin
      dy     = {cur_y_ff[pli_pkg::DATA_W-1], cur_y_ff} - {prev_y_ff[pli_pkg::DATA_W-1], prev_y_ff};
      dy_mag = dy[pli_pkg::DATA_W] ? (~dy + 1'b1) : dy;
      dq     = {query_ff[pli_pkg::DATA_W-1], query_ff} - {prev_x_ff[pli_pkg::DATA_W-1], prev_x_ff};
      dx     = {cur_x_ff[pli_pkg::DATA_W-1], cur_x_ff} - {prev_x_ff[pli_pkg::DATA_W-1], prev_x_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         neg_ff <= dy[pli_pkg::DATA_W];
         mag_ff <= dy_mag[pli_pkg::DATA_W-1:0];
         dq_ff  <= dq[pli_pkg::DATA_W-1:0];
         dx_ff  <= dx[pli_pkg::DATA_W-1:0];
         y0_ff  <= prev_y_ff;
      end
      if (cmd.mul) begin
         prod_ff <= 64'(mag_ff) * 64'(dq_ff);
      end
   end

   pli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      if (neg_ff) begin
         sum = {{2{y0_ff[pli_pkg::DATA_W-1]}}, y0_ff} - {2'b00, quotient};
      end else begin
         sum = {{2{y0_ff[pli_pkg::DATA_W-1]}}, y0_ff} + {2'b00, quotient};
      end
      sum_over  = !sum[pli_pkg::DATA_W+1] && (sum[pli_pkg::DATA_W:pli_pkg::DATA_W-1] != 2'b00);
      sum_under = sum[pli_pkg::DATA_W+1] && (sum[pli_pkg::DATA_W:pli_pkg::DATA_W-1] != 2'b11);
   end

   always_ff @(posedge clock) begin
      if (cmd.result_found) begin
         res_found_ff <= 1'b1;
         res_sat_ff   <= sum_over || sum_under;
         if (sum_over) begin
            res_value_ff <= {1'b0, {(pli_pkg::DATA_W-1){1'b1}}};
         end else if (sum_under) begin
            res_value_ff <= {1'b1, {(pli_pkg::DATA_W-1){1'b0}}};
         end else begin
            res_value_ff <= sum[pli_pkg::DATA_W-1:0];
         end
      end else if (cmd.result_miss) begin
         res_found_ff <= 1'b0;
         res_sat_ff   <= 1'b0;
         res_value_ff <= pli_pkg::ONE_Q16;
      end
   end

   // Output register; the next transaction can be in work while this one waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_found_ff <= res_found_ff;
         rsp_sat_ff   <= res_sat_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ===== rtl/core/pli_ctrl.sv =====
// Controller state machine that sequences loads, the scan, the arithmetic and the result.
module pli_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_cmd,
   output logic                     req_tready,
   input  pli_pkg::dp_status_type   status,
   output pli_pkg::ctrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DIFF,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FIX,
      ST_MISS,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_cmd == pli_pkg::CMD_LOAD) begin
                  cmd.write_point = 1'b1;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (status.few_points) begin
               state_in = ST_MISS;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.seg_valid) begin
               cmd.scan_step = 1'b1;
            end else if (status.seg_match) begin
               state_in = ST_DIFF;
            end else if (status.seg_last) begin
               state_in = ST_MISS;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.result_found = 1'b1;
            state_in         = ST_DONE;
         end
         ST_MISS: begin
            cmd.result_miss = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== test/piecewise_linear_interpolator_unit_test.sv =====
// Self-checking stream testbench for the piecewise linear interpolator with a built-in predictor.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_unit_test;

   localparam int TABLE_DEPTH = 256;
   // Transaction goal, directed and random together; the random phase runs until it is reached.
   localparam int ITEM_GOAL   = 625;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [31:0] value;
      logic        found;
      logic        saturated;
   } interp_result_type;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [103:0]                   req_tdata   = '0;
   logic [0:0]                     req_tuser   = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic [1:0]                     rsp_tuser;
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [pli_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [pli_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [pli_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // Predictor state: breakpoint table, point count and results still owed by the block.
   logic signed [31:0]          bp_x [TABLE_DEPTH];
   logic signed [31:0]          bp_y [TABLE_DEPTH];
   logic [pli_pkg::COUNT_W-1:0] active_points = '0;
   interp_result_type           pending_values [$];
   int                          failures      = 0;
   int                          sent_items    = 0;
   int                          cycle_count   = 0;
   bit                          steady_flow   = 1'b0;

   piecewise_linear_interpolator_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("piecewise_linear_interpolator_unit: mismatch");
         $finish;
      end
   end

   function automatic int draw_wait();
      return steady_flow ? 0 : $urandom_range(0, 12);
   endfunction

   // First segment with x[i] <= q < x[i+1] wins; the scaled quotient truncates toward zero.
   function automatic interp_result_type interpolate(input logic signed [31:0] qx);
      interp_result_type  res;
      int                 n;
      longint             q, x0, x1, y0, y1, dy, r;
      longint unsigned    mag, dq, dx, quo;
      logic               neg;
      res.value     = pli_pkg::ONE_Q16;
      res.found     = 1'b0;
      res.saturated = 1'b0;
      n = (active_points > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_points);
      q = longint'(qx);
      for (int i = 0; i + 1 < n; i++) begin
         x0 = longint'(bp_x[i]);
         x1 = longint'(bp_x[i + 1]);
         if (x0 <= q && q < x1) begin
            y0  = longint'(bp_y[i]);
            y1  = longint'(bp_y[i + 1]);
            dy  = y1 - y0;
            neg = dy < 0;
            mag = neg ? -dy : dy;
            dq  = q - x0;
            dx  = x1 - x0;
            quo = (mag * dq) / dx;
            r   = neg ? y0 - longint'(quo) : y0 + longint'(quo);
            res.found = 1'b1;
            if (r > longint'(Q_MAX)) begin
               r = longint'(Q_MAX);
               res.saturated = 1'b1;
            end else if (r < longint'(Q_MIN)) begin
               r = longint'(Q_MIN);
               res.saturated = 1'b1;
            end
            res.value = r[31:0];
            return res;
         end
      end
      return res;
   endfunction

   task automatic send_item(input logic [0:0] cmd, input logic [7:0] index,
                            input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] qx);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {qx, py, px, index};
      do @(posedge clock); while (!req_tready);
      if (cmd == pli_pkg::CMD_LOAD) begin
         bp_x[index] = px;
         bp_y[index] = py;
      end else begin
         pending_values.push_back(interpolate(qx));
      end
      sent_items++;
   endtask

   task automatic load_point(input logic [7:0] index, input logic [31:0] px,
                             input logic [31:0] py);
      send_item(pli_pkg::CMD_LOAD, index, px, py, $urandom);
   endtask

   task automatic query_at(input logic [31:0] qx);
      send_item(pli_pkg::CMD_QUERY, 8'($urandom), $urandom, $urandom, qx);
   endtask

   // Holds the stream idle until every owed result is back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pli_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == pli_pkg::ADDR_POINT_COUNT) active_points = data[pli_pkg::COUNT_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_check(input logic [pli_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] want);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) begin
         $error("point_count readback: expected %0d, got %0d", want, csr_prdata);
         failures++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_point_count(input logic [pli_pkg::COUNT_W-1:0] count);
      drain();
      csr_write(pli_pkg::ADDR_POINT_COUNT, 32'(count));
      csr_check(pli_pkg::ADDR_POINT_COUNT, 32'(count));
   endtask

   // Writes entries 0..n-1 with non-decreasing x, in forward or reverse index order.
   task automatic load_table(input int n, input logic signed [31:0] start, input int step_log);
      longint      x;
      logic [31:0] xs [$];
      bit          narrow_y, descend;
      int          idx;
      x        = longint'(start);
      narrow_y = 1'($urandom_range(0, 1));
      descend  = 1'($urandom_range(0, 1));
      for (int k = 0; k < n; k++) begin
         xs.push_back(x[31:0]);
         x = x + $urandom_range(0, 32'd1 << step_log);
         if (x > Q_MAX) x = longint'(Q_MAX);
      end
      for (int k = 0; k < n; k++) begin
         idx = descend ? n - 1 - k : k;
         load_point(8'(idx), xs[idx],
                    narrow_y ? $urandom_range(0, 2000) - 32'd1000 : $urandom);
      end
   endtask

   // Mostly points inside a segment, some on breakpoints, some anywhere, a few table rewrites.
   task automatic random_queries(input int n, input int count);
      int              i, kind, top;
      longint          x0, x1;
      longint unsigned off;
      logic [31:0]     q;
      top = (n > 1) ? n - 1 : 0;
      for (int k = 0; k < count; k++) begin
         kind = $urandom_range(0, 9);
         q    = $urandom;
         if (kind == 9) begin
            load_point(8'($urandom_range(0, top)), $urandom, $urandom);
         end else begin
            if (kind <= 5 && n >= 2) begin
               i  = $urandom_range(0, n - 2);
               x0 = longint'(bp_x[i]);
               x1 = longint'(bp_x[i + 1]);
               if (x1 > x0) begin
                  off = {$urandom, $urandom};
                  off = off % (x1 - x0);
                  q   = (kind == 5) ? 32'(x1 - 1) : 32'(x0 + off);
               end else begin
                  q = x0[31:0];
               end
            end else if (kind == 6) begin
               q = bp_x[$urandom_range(0, top)];
            end
            query_at(q);
         end
      end
   endtask

   task automatic test_few_points();
      query_at(32'h0);
      load_point(8'd0, 32'h0, Q_MAX);
      set_point_count(9'd1);
      query_at(32'h0);
   endtask

   // Extreme coordinates: full-scale slopes need the whole 64-bit product.
   task automatic test_segment_edges();
      load_point(8'd0, Q_MIN, Q_MAX);
      load_point(8'd1, -32'sd65536, Q_MIN);
      load_point(8'd2, 32'sd196608, 32'sd0);
      load_point(8'd3, Q_MAX, 32'sd100);
      set_point_count(9'd4);
      query_at(Q_MIN);
      query_at(-32'sd65537);
      query_at(-32'sd65536);
      query_at(32'sd0);
      query_at(32'sd196607);
      query_at(32'sd196608);
      query_at(Q_MAX - 1);
      query_at(Q_MAX);
   endtask

   // Out-of-order and zero-width segments: the lowest matching index must win.
   task automatic test_first_match();
      load_point(8'd2, -32'sd1073741824, 32'sd5000);
      query_at(-32'sd536870912);
      query_at(32'sd1000);
      load_point(8'd3, -32'sd1073741824, Q_MIN);
      query_at(32'sd5);
      query_at(-32'sd1073741824);
   endtask

   task automatic test_full_table();
      load_table(TABLE_DEPTH, Q_MIN + $urandom_range(0, 32'hFFFF), 24);
      set_point_count(pli_pkg::COUNT_W'(TABLE_DEPTH));
      random_queries(TABLE_DEPTH, 30);
      // A count above the table depth behaves as a full table.
      set_point_count(9'h1FF);
      random_queries(TABLE_DEPTH, 15);
   endtask

   task automatic test_random_tables();
      int n, pick;
      while (sent_items < ITEM_GOAL) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            n = $urandom_range(0, 1);
         end else if (pick <= 2) begin
            n = $urandom_range(13, TABLE_DEPTH);
         end else begin
            n = $urandom_range(2, 12);
            case ($urandom_range(0, 3))
               0: begin
                  load_table(n, $urandom, 31);
               end
               1: begin
                  load_table(n, $urandom, $urandom_range(4, 20));
               end
               2: begin
                  load_table(n, $urandom, 2);
               end
               default: begin
                  for (int k = 0; k < n; k++) load_point(8'(k), $urandom, $urandom);
               end
            endcase
         end
         set_point_count(pli_pkg::COUNT_W'(n));
         random_queries(n, (n > 12) ? $urandom_range(4, 10) : $urandom_range(8, 30));
      end
      steady_flow = 1'b0;
   endtask

   always begin : rsp_backpressure
      int stall;
      @(negedge clock);
      stall = draw_wait();
      if (stall > 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!rsp_tvalid);
   end

   always @(posedge clock) begin : rsp_compare
      interp_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_values.size() == 0) begin
            $error("unexpected result transaction: value %h, tuser %b", rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = pending_values.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("value: expected %h, got %h", want.value, rsp_tdata);
               failures++;
            end
            if (rsp_tuser[0] !== want.found) begin
               $error("found: expected %b, got %b", want.found, rsp_tuser[0]);
               failures++;
            end
            if (rsp_tuser[1] !== want.saturated) begin
               $error("saturated: expected %b, got %b", want.saturated, rsp_tuser[1]);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_few_points();
      test_segment_edges();
      test_first_match();
      test_full_table();
      test_random_tables();
      drain();
      // Long enough for a full-table query, so a stray result would still show up.
      repeat (400) @(posedge clock);
      if (failures == 0) begin
         $display("piecewise_linear_interpolator_unit: match");
      end else begin
         $display("piecewise_linear_interpolator_unit: mismatch");
      end
      $finish;
   end

endmodule
